// File: rtl/core/single_wire_pulse_width_serializer_macros.svh
// ----------------------------------------------------------------------------
// Single-wire pulse-width serializer assertion macros
// Shared wrappers for the concurrent assertions of the serializer checker.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_PULSE_WIDTH_SERIALIZER_MACROS_SVH
`define SINGLE_WIRE_PULSE_WIDTH_SERIALIZER_MACROS_SVH

// property checked on every clock edge outside reset
`define SWPW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SWPW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/swpw_pkg.sv
// ----------------------------------------------------------------------------
// swpw_pkg
// Types, register map and defaults of the single-wire pulse-width serializer.
// ----------------------------------------------------------------------------
package swpw_pkg;

  // width of each timing register and of its index
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // default parameter values
  localparam int DEF_TICK_COUNT_BITS = 10;
  localparam int DEF_DATA_BITS       = 8;

  // width of the data_byte field
  localparam int BYTE_W = 8;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    R_START_HIGH = 3'd0,
    R_ZERO_LOW   = 3'd1,
    R_ZERO_HIGH  = 3'd2,
    R_ONE_LOW    = 3'd3,
    R_ONE_HIGH   = 3'd4,
    R_END_LOW    = 3'd5,
    R_END_HIGH   = 3'd6
  } cfg_idx_t;

  // register reset values
  localparam logic [REG_W-1:0] RST_START_HIGH = 10'd15;
  localparam logic [REG_W-1:0] RST_ZERO_LOW   = 10'd12;
  localparam logic [REG_W-1:0] RST_ZERO_HIGH  = 10'd4;
  localparam logic [REG_W-1:0] RST_ONE_LOW    = 10'd4;
  localparam logic [REG_W-1:0] RST_ONE_HIGH   = 10'd12;
  localparam logic [REG_W-1:0] RST_END_LOW    = 10'd4;
  localparam logic [REG_W-1:0] RST_END_HIGH   = 10'd350;

  // timing registers as seen by the engine
  typedef struct packed {
    logic [REG_W-1:0] start_high;
    logic [REG_W-1:0] zero_low;
    logic [REG_W-1:0] zero_high;
    logic [REG_W-1:0] one_low;
    logic [REG_W-1:0] one_high;
    logic [REG_W-1:0] end_low;
    logic [REG_W-1:0] end_high;
  } cfg_t;

  // one result of the engine
  typedef struct packed {
    logic pin_level;
    logic busy;
    logic rejected;
  } res_t;

  // frame phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_START    = 6'b000010,
    PH_BIT_LOW  = 6'b000100,
    PH_BIT_HIGH = 6'b001000,
    PH_END_LOW  = 6'b010000,
    PH_END_HIGH = 6'b100000
  } phase_t;

endpackage

// File: rtl/core/swpw_cfg.sv
// ----------------------------------------------------------------------------
// swpw_cfg
// Timing register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module swpw_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swpw_pkg::REG_W-1:0]       cfg_data,
  output swpw_pkg::cfg_t                   cfg
);
  import swpw_pkg::*;

  // register writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_high <= RST_START_HIGH;
      cfg.zero_low   <= RST_ZERO_LOW;
      cfg.zero_high  <= RST_ZERO_HIGH;
      cfg.one_low    <= RST_ONE_LOW;
      cfg.one_high   <= RST_ONE_HIGH;
      cfg.end_low    <= RST_END_LOW;
      cfg.end_high   <= RST_END_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        R_START_HIGH: cfg.start_high <= cfg_data;
        R_ZERO_LOW:   cfg.zero_low   <= cfg_data;
        R_ZERO_HIGH:  cfg.zero_high  <= cfg_data;
        R_ONE_LOW:    cfg.one_low    <= cfg_data;
        R_ONE_HIGH:   cfg.one_high   <= cfg_data;
        R_END_LOW:    cfg.end_low    <= cfg_data;
        R_END_HIGH:   cfg.end_high   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/swpw_engine.sv
// ----------------------------------------------------------------------------
// swpw_engine
// Frame state machine: tick countdown, bit shifter and line level.
// ----------------------------------------------------------------------------
module swpw_engine #(
  parameter int TICK_COUNT_BITS = swpw_pkg::DEF_TICK_COUNT_BITS,
  parameter int DATA_BITS       = swpw_pkg::DEF_DATA_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          mode,
  input  logic [swpw_pkg::BYTE_W-1:0]   data_byte,
  input  swpw_pkg::cfg_t                cfg,
  output swpw_pkg::res_t                res
);
  import swpw_pkg::*;

  localparam int TW  = TICK_COUNT_BITS;
  localparam int CW  = (TW > REG_W) ? TW : REG_W;
  localparam int DW  = (DATA_BITS > BYTE_W) ? DATA_BITS : BYTE_W;
  localparam int BPW = $clog2(DATA_BITS + 1);

  phase_t                phase, phase_next;
  logic [BPW-1:0]        bit_position, bit_position_next;
  logic [TW-1:0]         ticks_left, ticks_left_next;
  logic [DATA_BITS-1:0]  shift_byte, shift_byte_next;
  logic                  line_level, line_level_next;
  logic                  busy;
  logic                  rej;
  logic [DATA_BITS-1:0]  shifted;
  logic [BPW-1:0]        bp_inc;
  logic [DW-1:0]         data_ext;

  // duration truncated or widened to the counter width
  function automatic logic [TW-1:0] load_ticks(input logic [REG_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[TW-1:0];
  endfunction

  assign busy     = (phase != PH_IDLE);
  assign shifted  = shift_byte << 1;
  assign bp_inc   = bit_position + BPW'(1);
  assign data_ext = DW'(data_byte);

  // next state for one request
  always_comb begin
    phase_next        = phase;
    bit_position_next = bit_position;
    ticks_left_next   = ticks_left;
    shift_byte_next   = shift_byte;
    line_level_next   = line_level;
    rej               = 1'b0;
    if (mode) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        shift_byte_next   = data_ext[DATA_BITS-1:0];
        bit_position_next = '0;
        phase_next        = PH_START;
        ticks_left_next   = load_ticks(cfg.start_high);
        line_level_next   = 1'b1;
      end
    end else if (busy) begin
      if (ticks_left <= TW'(1)) begin
        ticks_left_next = '0;
        unique case (phase)
          PH_START: begin
            phase_next      = PH_BIT_LOW;
            ticks_left_next = load_ticks(shift_byte[DATA_BITS-1] ? cfg.one_low : cfg.zero_low);
            line_level_next = 1'b0;
          end
          PH_BIT_LOW: begin
            phase_next      = PH_BIT_HIGH;
            ticks_left_next = load_ticks(shift_byte[DATA_BITS-1] ? cfg.one_high
                                                                  : cfg.zero_high);
            line_level_next = 1'b1;
          end
          PH_BIT_HIGH: begin
            shift_byte_next   = shifted;
            bit_position_next = bp_inc;
            line_level_next   = 1'b0;
            if (bp_inc >= BPW'(DATA_BITS)) begin
              phase_next      = PH_END_LOW;
              ticks_left_next = load_ticks(cfg.end_low);
            end else begin
              phase_next      = PH_BIT_LOW;
              ticks_left_next = load_ticks(shifted[DATA_BITS-1] ? cfg.one_low
                                                                 : cfg.zero_low);
            end
          end
          PH_END_LOW: begin
            phase_next      = PH_END_HIGH;
            ticks_left_next = load_ticks(cfg.end_high);
            line_level_next = 1'b1;
          end
          default: begin
            // end of closing high period: back to idle with the line high
            phase_next        = PH_IDLE;
            bit_position_next = '0;
            line_level_next   = 1'b1;
          end
        endcase
      end else begin
        ticks_left_next = ticks_left - TW'(1);
      end
    end
  end

  // state update on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_position <= '0;
      ticks_left   <= '0;
      shift_byte   <= '0;
      line_level   <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      bit_position <= bit_position_next;
      ticks_left   <= ticks_left_next;
      shift_byte   <= shift_byte_next;
      line_level   <= line_level_next;
    end
  end

  assign res.pin_level = line_level_next;
  assign res.busy      = (phase_next != PH_IDLE);
  assign res.rejected  = rej;

endmodule

// File: rtl/core/single_wire_pulse_width_serializer.sv
// A request accepted into the input register moves to the result register as it fires,
// which a stalled result can hold off. Throughput: one request per cycle while no stall
// holds the result; the input register and the result register each hold one request,
// and the frame state advances by one request each time a request fires.
// Reset (rst, synchronous): idle, engine line level low, timing registers at their
// defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
// single_wire_pulse_width_serializer
// Drives a pulse-width coded single-wire line from tick and send requests.
// ----------------------------------------------------------------------------
module single_wire_pulse_width_serializer #(
  parameter int TICK_COUNT_BITS = swpw_pkg::DEF_TICK_COUNT_BITS,
  parameter int DATA_BITS       = swpw_pkg::DEF_DATA_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [swpw_pkg::BYTE_W-1:0]     data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            pin_level,
  output logic                            busy_res,
  output logic                            rejected,
  input  logic                            cfg_we,
  input  logic [swpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swpw_pkg::REG_W-1:0]      cfg_data
);
  import swpw_pkg::*;

  logic               in_q_valid;
  logic               mode_q;
  logic [BYTE_W-1:0]  data_q;
  logic               out_free;
  logic               fire;
  logic               in_accept;
  cfg_t               cfg;
  res_t               res;

  // handshake control
  assign out_free  = !out_valid || !out_stall;
  assign fire      = in_q_valid && out_free;
  assign in_stall  = in_q_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q <= mode;
      data_q <= data_byte;
    end
  end

  // timing registers
  swpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // frame engine
  swpw_engine #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS),
    .DATA_BITS       (DATA_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .mode      (mode_q),
    .data_byte (data_q),
    .cfg       (cfg),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pin_level <= res.pin_level;
      busy_res  <= res.busy;
      rejected  <= res.rejected;
    end
  end

endmodule

// File: rtl/core/swpw_checker.sv
// ----------------------------------------------------------------------------
// swpw_checker
// Port-level assertions for the single-wire pulse-width serializer.
// ----------------------------------------------------------------------------
`include "single_wire_pulse_width_serializer_macros.svh"

module swpw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic pin_level,
  input logic busy_res,
  input logic rejected
);

  // a held result stays offered
  `SWPW_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // a held result keeps its payload
  `SWPW_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable({pin_level, busy_res, rejected}), "payload changed while stalled")

  // a rejected send only happens during a frame, which keeps going
  `SWPW_ASSERT(a_rej_busy, clk, rst, out_valid && rejected |-> busy_res, "rejected request without busy frame")

  // reset empties both pipeline registers
  `SWPW_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind single_wire_pulse_width_serializer swpw_checker u_swpw_checker (.*);
